// ----- rtl/snlp_pkg.sv -----
// Shared types, widths and register codes for the segment nearest point block.
`default_nettype none
package snlp_pkg;

    // Field widths fixed by the coordinate and time formats.
    localparam int COORD_W = 24;
    localparam int WIDTH_W = 24;
    localparam int TIME_W  = 32;
    localparam int DIST_W  = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int BOX_W   = COORD_W + 3;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int DEN_W   = PROD_W + 1;
    localparam int DX_W    = COORD_W + 3;
    localparam int SQ_W    = 2 * DX_W;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int SREM_W  = ROOT_W + 2;
    localparam int IN_W    = 2 * COORD_W;

    // Defaults for the module parameters.
    localparam int COORD_FRAC_BITS_DEF = 8;
    localparam int FRACTION_BITS_DEF   = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TIME_W;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME    = 3'd7;

    // Which part of the segment is nearest.
    typedef enum logic [1:0] {
        REG_START    = 2'd0,
        REG_END      = 2'd1,
        REG_INTERIOR = 2'd2
    } t_region;

    // Segment configuration as held in registers.
    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [WIDTH_W-1:0]        start_width;
        logic [WIDTH_W-1:0]        end_width;
        logic signed [TIME_W-1:0]  start_time;
        logic signed [TIME_W-1:0]  end_time;
    } t_cfg;

    // Classified point handed from the front to the back.
    typedef struct packed {
        logic                      in_box;
        t_region                   region;
        logic signed [DEN_W-1:0]   proj;
        logic [DEN_W-1:0]          den;
        logic signed [DIFF_W-1:0]  qx;
        logic signed [DIFF_W-1:0]  qy;
    } t_item;

endpackage
`default_nettype wire

// ----- rtl/snlp_front.sv -----
// Front part: box test, projection and classification of each query point.
`default_nettype none
module snlp_front #(
    parameter int COORD_FRAC_BITS = snlp_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire snlp_pkg::t_cfg           i_cfg,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [snlp_pkg::IN_W-1:0] i_data,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output snlp_pkg::t_item               o_item
);
    import snlp_pkg::*;

    localparam logic [BOX_W-1:0] UNIT = BOX_W'(1) << COORD_FRAC_BITS;

    logic                     en;
    logic signed [COORD_W-1:0] px, py;
    logic [WIDTH_W-1:0]       max_w;
    logic signed [BOX_W-1:0]  grow, lo_x, hi_x, lo_y, hi_y, bpx, bpy;
    logic signed [BOX_W-1:0]  ax, ay, bx, by;
    logic signed [DIFF_W-1:0] sx, sy;
    logic                     n_in_box;

    logic                     r_s1_valid, r_s1_in_box;
    logic signed [DIFF_W-1:0] r_s1_qx, r_s1_qy;
    logic                     r_s2_valid, r_s2_in_box;
    logic signed [DIFF_W-1:0] r_s2_qx, r_s2_qy;
    logic signed [PROD_W-1:0] r_s2_pxx, r_s2_pyy, r_s2_dxx, r_s2_dyy;
    logic                     r_s3_valid;
    t_item                    r_s3_item;
    logic signed [DEN_W-1:0]  n_proj, n_den;
    t_region                  n_region;

    assign en      = !r_s3_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_s3_valid;
    assign o_item  = r_s3_item;

    // Expanded bounding box of the segment and the inclusive test.
    always_comb begin
        px    = i_data[COORD_W-1:0];
        py    = i_data[IN_W-1:COORD_W];
        max_w = (i_cfg.start_width > i_cfg.end_width) ? i_cfg.start_width : i_cfg.end_width;
        grow  = $signed(BOX_W'(max_w) + UNIT);
        ax    = BOX_W'(i_cfg.start_x);
        ay    = BOX_W'(i_cfg.start_y);
        bx    = BOX_W'(i_cfg.end_x);
        by    = BOX_W'(i_cfg.end_y);
        lo_x  = ((ax < bx) ? ax : bx) - grow;
        hi_x  = ((ax > bx) ? ax : bx) + grow;
        lo_y  = ((ay < by) ? ay : by) - grow;
        hi_y  = ((ay > by) ? ay : by) + grow;
        bpx   = BOX_W'(px);
        bpy   = BOX_W'(py);
        n_in_box = (bpx >= lo_x) && (bpx <= hi_x) && (bpy >= lo_y) && (bpy <= hi_y);
        sx    = DIFF_W'(i_cfg.end_x) - DIFF_W'(i_cfg.start_x);
        sy    = DIFF_W'(i_cfg.end_y) - DIFF_W'(i_cfg.start_y);
    end

    // Stage one: box result and offset from the start point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_valid;
        end
        if (en) begin
            r_s1_in_box <= n_in_box;
            r_s1_qx     <= DIFF_W'(px) - DIFF_W'(i_cfg.start_x);
            r_s1_qy     <= DIFF_W'(py) - DIFF_W'(i_cfg.start_y);
        end
    end

    // Stage two: the four products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
        if (en) begin
            r_s2_in_box <= r_s1_in_box;
            r_s2_qx     <= r_s1_qx;
            r_s2_qy     <= r_s1_qy;
            r_s2_pxx    <= sx * r_s1_qx;
            r_s2_pyy    <= sy * r_s1_qy;
            r_s2_dxx    <= sx * sx;
            r_s2_dyy    <= sy * sy;
        end
    end

    // Stage three: projection, squared length and the region.
    always_comb begin
        n_proj = DEN_W'(r_s2_pxx) + DEN_W'(r_s2_pyy);
        n_den  = DEN_W'(r_s2_dxx) + DEN_W'(r_s2_dyy);
        if (n_proj <= 0) begin
            n_region = REG_START;
        end else if (n_proj >= n_den) begin
            n_region = REG_END;
        end else begin
            n_region = REG_INTERIOR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid;
        end
        if (en) begin
            r_s3_item.in_box <= r_s2_in_box;
            r_s3_item.region <= n_region;
            r_s3_item.proj   <= n_proj;
            r_s3_item.den    <= n_den;
            r_s3_item.qx     <= r_s2_qx;
            r_s3_item.qy     <= r_s2_qy;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/snlp_queue.sv -----
// Two-entry queue between the front and the back part.
`default_nettype none
module snlp_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire snlp_pkg::t_item i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output snlp_pkg::t_item      o_item
);
    import snlp_pkg::*;

    t_item       r_mem [2];
    logic        r_wr, r_rd;
    logic [1:0]  r_count;
    logic        push, pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = i_ready && o_valid;
    assign o_item  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/snlp_back.sv -----
// Back part: fraction divider, foot point, interpolation and square root pipeline.
`default_nettype none
module snlp_back #(
    parameter int FRACTION_BITS = snlp_pkg::FRACTION_BITS_DEF,
    parameter int OUT_W         = 104
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire snlp_pkg::t_cfg  i_cfg,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire snlp_pkg::t_item i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [OUT_W-1:0]     o_data
);
    import snlp_pkg::*;

    localparam int FR_W  = FRACTION_BITS + 1;
    localparam int MUL_W = DIFF_W + FRACTION_BITS + 2;
    localparam int TMU_W = TIME_W + FRACTION_BITS + 3;
    localparam logic signed [MUL_W-1:0] HALF = MUL_W'(1) << (FRACTION_BITS - 1);
    localparam logic [FR_W-1:0] ONE = FR_W'(1) << FRACTION_BITS;
    localparam int USED_W = 3 + FR_W + DIST_W + WIDTH_W + TIME_W;

    typedef struct packed {
        logic                     valid;
        logic                     in_box;
        t_region                  region;
        logic [DEN_W:0]           rem;
        logic [DEN_W-1:0]         den;
        logic [FRACTION_BITS-1:0] q;
        logic signed [DIFF_W-1:0] qx;
        logic signed [DIFF_W-1:0] qy;
    } t_dv;

    typedef struct packed {
        logic                valid;
        logic                in_box;
        t_region             region;
        logic [FR_W-1:0]     t;
        logic [WIDTH_W-1:0]  w;
        logic [TIME_W-1:0]   tm;
        logic [SQ_W-1:0]     v;
        logic [ROOT_W-1:0]   root;
        logic [SREM_W-1:0]   rem;
    } t_sq;

    // One restoring division step, one quotient bit.
    function automatic t_dv div_step(input t_dv s);
        t_dv        d;
        logic [DEN_W:0] sh;
        d  = s;
        sh = {s.rem[DEN_W-1:0], 1'b0};
        if (sh >= {1'b0, s.den}) begin
            d.rem = sh - {1'b0, s.den};
            d.q   = {s.q[FRACTION_BITS-2:0], 1'b1};
        end else begin
            d.rem = sh;
            d.q   = {s.q[FRACTION_BITS-2:0], 1'b0};
        end
        return d;
    endfunction

    // One square root step, one root bit from two radicand bits.
    function automatic t_sq sqrt_step(input t_sq s);
        t_sq             d;
        logic [SREM_W+1:0] cur, trial;
        d     = s;
        cur   = {s.rem, s.v[SQ_W-1 -: 2]};
        trial = (SREM_W + 2)'({s.root, 2'b01});
        if (cur >= trial) begin
            d.rem  = SREM_W'(cur - trial);
            d.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            d.rem  = SREM_W'(cur);
            d.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        d.v = {s.v[SQ_W-3:0], 2'b00};
        return d;
    endfunction

    logic                       en;
    t_dv                        r_dv [FRACTION_BITS+1];
    t_sq                        r_sq [ROOT_W+1];
    logic [FR_W-1:0]            n_t;
    logic signed [DIFF_W-1:0]   sx, sy;
    logic signed [DIFF_W-1:0]   dw;
    logic signed [TIME_W:0]     dt;

    logic                       r_m1_valid, r_m1_in_box;
    t_region                    r_m1_region;
    logic [FR_W-1:0]            r_m1_t;
    logic signed [DIFF_W-1:0]   r_m1_qx, r_m1_qy;
    logic signed [MUL_W-1:0]    r_m1_psx, r_m1_psy, r_m1_pw;
    logic signed [TMU_W-1:0]    r_m1_pt;

    logic                       r_m2_valid, r_m2_in_box;
    t_region                    r_m2_region;
    logic [FR_W-1:0]            r_m2_t;
    logic signed [DX_W-1:0]     r_m2_dx, r_m2_dy;
    logic [WIDTH_W-1:0]         r_m2_w;
    logic [TIME_W-1:0]          r_m2_tm;

    logic                       r_m3_valid, r_m3_in_box;
    t_region                    r_m3_region;
    logic [FR_W-1:0]            r_m3_t;
    logic signed [SQ_W-1:0]     r_m3_sqx, r_m3_sqy;
    logic [WIDTH_W-1:0]         r_m3_w;
    logic [TIME_W-1:0]          r_m3_tm;

    logic                       r_out_valid;
    logic [USED_W-1:0]          r_out_data;
    logic [DIST_W-1:0]          n_dist;
    t_sq                        last;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_valid;
    assign o_data  = OUT_W'(r_out_data);

    assign sx = DIFF_W'(i_cfg.end_x) - DIFF_W'(i_cfg.start_x);
    assign sy = DIFF_W'(i_cfg.end_y) - DIFF_W'(i_cfg.start_y);
    assign dw = $signed({1'b0, i_cfg.end_width}) - $signed({1'b0, i_cfg.start_width});
    assign dt = (TIME_W + 1)'(i_cfg.end_time) - (TIME_W + 1)'(i_cfg.start_time);

    // Divider entry loaded from the queue head.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].valid <= 1'b0;
        end else if (en) begin
            r_dv[0].valid <= i_valid;
        end
        if (en) begin
            r_dv[0].in_box <= i_item.in_box;
            r_dv[0].region <= i_item.region;
            r_dv[0].rem    <= {1'b0, i_item.proj};
            r_dv[0].den    <= i_item.den;
            r_dv[0].q      <= '0;
            r_dv[0].qx     <= i_item.qx;
            r_dv[0].qy     <= i_item.qy;
        end
    end

    // Divider stages.
    for (genvar g = 0; g < FRACTION_BITS; g++) begin : g_div
        t_dv n_dv;
        assign n_dv = div_step(r_dv[g]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[g+1].valid <= 1'b0;
            end else if (en) begin
                r_dv[g+1].valid <= r_dv[g].valid;
            end
            if (en) begin
                r_dv[g+1].in_box <= n_dv.in_box;
                r_dv[g+1].region <= n_dv.region;
                r_dv[g+1].rem    <= n_dv.rem;
                r_dv[g+1].den    <= n_dv.den;
                r_dv[g+1].q      <= n_dv.q;
                r_dv[g+1].qx     <= n_dv.qx;
                r_dv[g+1].qy     <= n_dv.qy;
            end
        end
    end

    // Fraction by region; endpoints fall out of the same formulas.
    always_comb begin
        case (r_dv[FRACTION_BITS].region)
            REG_INTERIOR: n_t = FR_W'(r_dv[FRACTION_BITS].q);
            REG_END:      n_t = ONE;
            default:      n_t = '0;
        endcase
    end

    // Products with the fraction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (en) begin
            r_m1_valid <= r_dv[FRACTION_BITS].valid;
        end
        if (en) begin
            r_m1_in_box <= r_dv[FRACTION_BITS].in_box;
            r_m1_region <= r_dv[FRACTION_BITS].region;
            r_m1_t      <= n_t;
            r_m1_qx     <= r_dv[FRACTION_BITS].qx;
            r_m1_qy     <= r_dv[FRACTION_BITS].qy;
            r_m1_psx    <= sx * $signed({1'b0, n_t}) + HALF;
            r_m1_psy    <= sy * $signed({1'b0, n_t}) + HALF;
            r_m1_pw     <= dw * $signed({1'b0, n_t});
            r_m1_pt     <= dt * $signed({1'b0, n_t});
        end
    end

    // Foot point offsets and interpolated width and time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (en) begin
            r_m2_valid <= r_m1_valid;
        end
        if (en) begin
            r_m2_in_box <= r_m1_in_box;
            r_m2_region <= r_m1_region;
            r_m2_t      <= r_m1_t;
            r_m2_dx     <= $signed(r_m1_psx[FRACTION_BITS +: DX_W]) - DX_W'(r_m1_qx);
            r_m2_dy     <= $signed(r_m1_psy[FRACTION_BITS +: DX_W]) - DX_W'(r_m1_qy);
            r_m2_w      <= i_cfg.start_width + r_m1_pw[FRACTION_BITS +: WIDTH_W];
            r_m2_tm     <= i_cfg.start_time + r_m1_pt[FRACTION_BITS +: TIME_W];
        end
    end

    // Squares of the offsets.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_valid <= 1'b0;
        end else if (en) begin
            r_m3_valid <= r_m2_valid;
        end
        if (en) begin
            r_m3_in_box <= r_m2_in_box;
            r_m3_region <= r_m2_region;
            r_m3_t      <= r_m2_t;
            r_m3_sqx    <= r_m2_dx * r_m2_dx;
            r_m3_sqy    <= r_m2_dy * r_m2_dy;
            r_m3_w      <= r_m2_w;
            r_m3_tm     <= r_m2_tm;
        end
    end

    // Square root entry: sum of squares.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq[0].valid <= 1'b0;
        end else if (en) begin
            r_sq[0].valid <= r_m3_valid;
        end
        if (en) begin
            r_sq[0].in_box <= r_m3_in_box;
            r_sq[0].region <= r_m3_region;
            r_sq[0].t      <= r_m3_t;
            r_sq[0].w      <= r_m3_w;
            r_sq[0].tm     <= r_m3_tm;
            r_sq[0].v      <= r_m3_sqx + r_m3_sqy;
            r_sq[0].root   <= '0;
            r_sq[0].rem    <= '0;
        end
    end

    // Square root stages.
    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        t_sq n_sq;
        assign n_sq = sqrt_step(r_sq[g]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[g+1].valid <= 1'b0;
            end else if (en) begin
                r_sq[g+1].valid <= r_sq[g].valid;
            end
            if (en) begin
                r_sq[g+1].in_box <= n_sq.in_box;
                r_sq[g+1].region <= n_sq.region;
                r_sq[g+1].t      <= n_sq.t;
                r_sq[g+1].w      <= n_sq.w;
                r_sq[g+1].tm     <= n_sq.tm;
                r_sq[g+1].v      <= n_sq.v;
                r_sq[g+1].root   <= n_sq.root;
                r_sq[g+1].rem    <= n_sq.rem;
            end
        end
    end

    // Saturation of the distance.
    assign last   = r_sq[ROOT_W];
    assign n_dist = (last.root > ROOT_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
                                                          : last.root[DIST_W-1:0];

    // Output word; a miss forces the fixed miss result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last.valid;
        end
        if (en) begin
            if (last.in_box) begin
                r_out_data <= {last.tm, last.w, n_dist, last.t, last.region, 1'b1};
            end else begin
                r_out_data <= {{TIME_W{1'b0}}, {WIDTH_W{1'b0}}, {DIST_W{1'b1}},
                               {FR_W{1'b0}}, REG_START, 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/segment_nearest_point_lerp.sv -----
// Top level of the segment nearest point block with width and time interpolation.
// Takes one query point per word and returns one result word for each, in order, at a
// sustained rate of one word per clock cycle while the output is not stalled. Each
// accepted input word passes through the three-stage front (box test, products,
// projection), the two-entry queue, the one-bit-per-stage fraction divider, the
// multiply stages and the 27-stage square root pipeline to its result word.
// Configuration registers are written through the plain write port and must be
// changed only while no word is in flight.
`default_nettype none
module segment_nearest_point_lerp #(
    parameter int COORD_FRAC_BITS = snlp_pkg::COORD_FRAC_BITS_DEF,
    parameter int FRACTION_BITS   = snlp_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [snlp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [snlp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // point_x, point_y
    input  wire logic [snlp_pkg::IN_W-1:0]       i_s_tdata,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // in_box, region, fraction, distance, width_at_hit, time_at_hit, zero pad
    output logic [((3 + FRACTION_BITS + 1 + 80 + 7) / 8) * 8 - 1:0] o_m_tdata
);
    import snlp_pkg::*;

    localparam int OUT_W = ((3 + FRACTION_BITS + 1 + 80 + 7) / 8) * 8;

    t_cfg  r_cfg;
    logic  front_valid, front_ready, back_valid, back_ready;
    t_item front_item, back_item;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_X:     r_cfg.start_x     <= i_cfg_data[COORD_W-1:0];
                CFG_START_Y:     r_cfg.start_y     <= i_cfg_data[COORD_W-1:0];
                CFG_END_X:       r_cfg.end_x       <= i_cfg_data[COORD_W-1:0];
                CFG_END_Y:       r_cfg.end_y       <= i_cfg_data[COORD_W-1:0];
                CFG_START_WIDTH: r_cfg.start_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_END_WIDTH:   r_cfg.end_width   <= i_cfg_data[WIDTH_W-1:0];
                CFG_START_TIME:  r_cfg.start_time  <= i_cfg_data;
                CFG_END_TIME:    r_cfg.end_time    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    snlp_front #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_item  (front_item)
    );

    snlp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (back_valid),
        .i_ready (back_ready),
        .o_item  (back_item)
    );

    snlp_back #(
        .FRACTION_BITS(FRACTION_BITS),
        .OUT_W        (OUT_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (back_valid),
        .o_ready (back_ready),
        .i_item  (back_item),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata)
    );

endmodule
`default_nettype wire
